// ===== hdl/rclfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rclfs_pkg: shared types and constants for the RC link failsafe scaler
// Field widths, fixed-point constants, register codes, sequencer states and
// the small rounding helpers used by the stick scaling path.
// ----------------------------------------------------------------------------
package rclfs_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam int DT_W    = 20;
  localparam int QUAL_W  = 15;
  localparam int SCALE_W = 16;
  localparam int STICK_W = 16;
  localparam int US_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 32;
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 15;
  localparam int DIV_Q_W = 16;

  localparam logic [QUAL_W-1:0]  FULL_QUALITY = 15'd25600;
  localparam logic [SCALE_W-1:0] UNITY_SCALE  = 16'd32768;

  localparam logic [QUAL_W-1:0]  DEGRADED_RESET = 15'd17920;
  localparam logic [QUAL_W-1:0]  CRITICAL_RESET = 15'd10240;
  localparam logic [QUAL_W-1:0]  CUTOFF_RESET   = 15'd2560;
  localparam logic [SCALE_W-1:0] MIN_SCALE_RESET  = 16'd8192;
  localparam logic [SCALE_W-1:0] CRIT_SCALE_RESET = 16'd19661;
  localparam logic [US_W-1:0]    TIMEOUT_RESET = 32'd500000;
  localparam logic [US_W-1:0]    HOLD_RESET    = 32'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGRADED_QUALITY = 3'd0,
    REG_CRITICAL_QUALITY = 3'd1,
    REG_CUTOFF_QUALITY   = 3'd2,
    REG_MINIMUM_SCALE    = 3'd3,
    REG_CRITICAL_SCALE   = 3'd4,
    REG_PACKET_TIMEOUT   = 3'd5,
    REG_HOLD_TIME        = 3'd6,
    REG_PACKET_MODE      = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SEG_MUL,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_SCALE,
    ST_MUL_PITCH,
    ST_MUL_ROLL,
    ST_MUL_YAW,
    ST_YAW_CAP,
    ST_COMMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    SEG_LO,
    SEG_HI,
    SEG_DIV
  } seg_kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Magnitude of a signed stick value; -32768 gives 32768.
  function automatic logic [MUL_A_W-1:0] abs_stick(input logic [STICK_W-1:0] v);
    logic [MUL_A_W-1:0] x;
    x = {v[STICK_W-1], v};
    return v[STICK_W-1] ? (~x + 17'd1) : x;
  endfunction

  // Product magnitude / 32768, rounded half away from zero, sign restored.
  function automatic logic [STICK_W-1:0] round_stick(input logic neg,
                                                     input logic [PROD_W-1:0] prod);
    logic [PROD_W-1:0] sum;
    logic [16:0] mag;
    logic [16:0] res;
    sum = prod + 32'd16384;
    mag = sum[31:15];
    res = neg ? (~mag + 17'd1) : mag;
    return res[STICK_W-1:0];
  endfunction

endpackage

// ===== hdl/rclfs_mul.sv =====
// ----------------------------------------------------------------------------
// rclfs_mul: shared unsigned multiplier with a registered product
// Used in turn for the segment interpolation and for the three scaled sticks.
// ----------------------------------------------------------------------------
module rclfs_mul (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rclfs_pkg::MUL_A_W-1:0] a,
  input  logic [rclfs_pkg::MUL_B_W-1:0] b,
  output logic [rclfs_pkg::PROD_W-1:0]  prod
);
  import rclfs_pkg::*;

  logic [MUL_A_W+MUL_B_W-1:0] full;

  assign full = a * b;

  // Operand ranges keep the product below 2^31.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[PROD_W-1:0];
    end
  end

endmodule

// ===== hdl/rclfs_div.sv =====
// ----------------------------------------------------------------------------
// rclfs_div: radix-2 restoring divider, one quotient bit per cycle
// The dividend must be below divisor * 2^16, so the quotient fits 16 bits.
// ----------------------------------------------------------------------------
module rclfs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rclfs_pkg::DIV_N_W-1:0] dividend,
  input  logic [rclfs_pkg::DIV_D_W-1:0] divisor,
  output logic [rclfs_pkg::DIV_Q_W-1:0] quotient,
  output rclfs_pkg::div_status_t        status
);
  import rclfs_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic [DIV_D_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [DIV_D_W:0]   trial;
  logic               take;
  logic [DIV_D_W:0]   diff;

  assign trial = {rem, quotient[DIV_Q_W-1]};
  assign take  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The upper half of the dividend is already below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[DIV_N_W-2 -: DIV_D_W];
      quotient <= dividend[DIV_Q_W-1:0];
    end else if (busy) begin
      rem      <= take ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quotient <= {quotient[DIV_Q_W-2:0], take};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== hdl/rc_link_failsafe_input_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// rc_link_failsafe_input_scaler_unit: stick scaling and failsafe for an RC link
// Per control tick, derives a stick scale from link quality, tracks packet
// age and failsafe hold time, and delivers throttle plus scaled attitude sticks.
// ----------------------------------------------------------------------------
// Usage: one control tick enters as a word on the s_t* channel; one result
// word leaves on the m_t* channel for every tick. Registers are written on
// the cfg_* channel, which is always ready; write them only while the block
// is idle with no result pending.
// Sequencing: the block works on one tick at a time; it accepts the next
// tick only once the result of the last is committed to the output
// register. The time a tick takes is set by the restoring divider of the
// quality interpolation and by the single shared multiplier that serves
// the interpolation and the three attitude sticks in turn. Ticks that need
// no interpolation skip the multiply and divide.
// Stalls: the result sits in an output register; while the receiver holds
// m_tready low the word stays stable, the next tick may already be accepted
// and worked on, and it waits in its final step until the register frees.
// Reset: rst is synchronous and active high. It restores all register
// defaults, clears failsafe, the packet age, the failsafe timer and the held
// sticks, and drops any result not yet taken.
// ----------------------------------------------------------------------------
module rc_link_failsafe_input_scaler_unit #(
  parameter int TIME_BITS = rclfs_pkg::TIME_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // Input word, from bit 0: elapsed_us[20], link_quality[15], quality_valid[1],
  // packet_arrived[1], throttle_in[16], pitch_in[16], roll_in[16], yaw_in[16],
  // then three zero bits.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,
  // Result word, from bit 0: throttle_out[16], pitch_out[16], roll_out[16],
  // yaw_out[16], input_scale[16], failsafe_active[1], packet_seen[1],
  // then six zero bits.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [87:0]  m_tdata,
  // Register write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rclfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rclfs_pkg::US_W-1:0]        cfg_data
);
  import rclfs_pkg::*;

  localparam int SUM_W = ((TIME_BITS > DT_W) ? TIME_BITS : DT_W) + 1;
  localparam int CMP_W = (TIME_BITS > US_W) ? TIME_BITS : US_W;
  localparam logic [SUM_W-1:0] TIME_MAX = (SUM_W'(1) << TIME_BITS) - SUM_W'(1);

  // Configuration registers.
  logic [QUAL_W-1:0]  degraded_quality, critical_quality, cutoff_quality;
  logic [SCALE_W-1:0] minimum_scale, critical_scale;
  logic [US_W-1:0]    packet_timeout_us, hold_time_us;
  logic               packet_mode;

  // Latched input word.
  logic [DT_W-1:0]    in_dt;
  logic [QUAL_W-1:0]  in_q;
  logic               in_arrived;
  logic [STICK_W-1:0] in_throttle, in_pitch, in_roll, in_yaw;

  // Link and hold state.
  logic                 in_failsafe;
  logic [TIME_BITS-1:0] packet_age, failsafe_elapsed;
  logic [STICK_W-1:0]   held_throttle, held_pitch, held_roll, held_yaw;

  // Interpolation working registers.
  seg_kind_t          seg_kind;
  logic [SCALE_W-1:0] seg_lo, seg_hi, seg_dmag;
  logic               seg_neg;
  logic [QUAL_W-1:0]  seg_num, seg_den;
  logic [SCALE_W-1:0] scale;
  logic [STICK_W-1:0] pitch_scaled, roll_scaled, yaw_scaled;

  // Sequencer.
  seq_state_t state, state_next;

  // Shared units.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_en;
  logic [PROD_W-1:0]  prod;
  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_Q_W-1:0] div_quot;
  div_status_t        div_stat;

  rclfs_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rclfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (seg_den),
    .quotient (div_quot),
    .status   (div_stat)
  );

  assign div_dividend = prod + {{(DIV_N_W - QUAL_W + 1){1'b0}}, seg_den[QUAL_W-1:1]};

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the cycle they are offered.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      degraded_quality  <= DEGRADED_RESET;
      critical_quality  <= CRITICAL_RESET;
      cutoff_quality    <= CUTOFF_RESET;
      minimum_scale     <= MIN_SCALE_RESET;
      critical_scale    <= CRIT_SCALE_RESET;
      packet_timeout_us <= TIMEOUT_RESET;
      hold_time_us      <= HOLD_RESET;
      packet_mode       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEGRADED_QUALITY: degraded_quality  <= cfg_data[QUAL_W-1:0];
        REG_CRITICAL_QUALITY: critical_quality  <= cfg_data[QUAL_W-1:0];
        REG_CUTOFF_QUALITY:   cutoff_quality    <= cfg_data[QUAL_W-1:0];
        REG_MINIMUM_SCALE:    minimum_scale     <= cfg_data[SCALE_W-1:0];
        REG_CRITICAL_SCALE:   critical_scale    <= cfg_data[SCALE_W-1:0];
        REG_PACKET_TIMEOUT:   packet_timeout_us <= cfg_data;
        REG_HOLD_TIME:        hold_time_us      <= cfg_data;
        REG_PACKET_MODE:      packet_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Segment selection. The quality picks the upper segment, the lower
  // segment, or unity; the endpoint cases are settled here so that only a
  // quality strictly inside a segment goes through the multiply and divide.
  // --------------------------------------------------------------------------
  seg_kind_t          su_kind;
  logic [QUAL_W-1:0]  su_a, su_b;
  logic [SCALE_W-1:0] su_lo, su_hi, su_dmag;
  logic signed [QUAL_W+1:0] su_num, su_den, su_nn, su_dd;
  logic signed [SCALE_W:0]  su_delta;

  always_comb begin
    su_a  = critical_quality;
    su_b  = degraded_quality;
    su_lo = critical_scale;
    su_hi = UNITY_SCALE;
    if (in_q <= critical_quality) begin
      su_a  = cutoff_quality;
      su_b  = critical_quality;
      su_lo = minimum_scale;
      su_hi = critical_scale;
    end
    su_num = $signed({2'b00, in_q}) - $signed({2'b00, su_a});
    su_den = $signed({2'b00, su_b}) - $signed({2'b00, su_a});
    // Inverted bounds use the same formula with both signs flipped.
    su_nn  = (su_den < 0) ? -su_num : su_num;
    su_dd  = (su_den < 0) ? -su_den : su_den;
    su_delta = $signed({1'b0, su_hi}) - $signed({1'b0, su_lo});
    su_dmag  = (su_delta < 0) ? SCALE_W'(-su_delta) : SCALE_W'(su_delta);
    if (in_q >= degraded_quality) begin
      su_kind = SEG_HI;
      su_hi   = UNITY_SCALE;
    end else if (su_den == 0) begin
      su_kind = (in_q >= su_b) ? SEG_HI : SEG_LO;
    end else if (su_nn <= 0) begin
      su_kind = SEG_LO;
    end else if (su_nn >= su_dd) begin
      su_kind = SEG_HI;
    end else begin
      su_kind = SEG_DIV;
    end
  end

  // Scale from the segment result, saturated to unity.
  logic [SCALE_W:0]   sc_val;
  logic [SCALE_W-1:0] sc_next;

  always_comb begin
    case (seg_kind)
      SEG_LO:  sc_val = {1'b0, seg_lo};
      SEG_HI:  sc_val = {1'b0, seg_hi};
      SEG_DIV: sc_val = seg_neg ? ({1'b0, seg_lo} - {1'b0, div_quot})
                                : ({1'b0, seg_lo} + {1'b0, div_quot});
      default: sc_val = '0;
    endcase
    sc_next = (sc_val > {1'b0, UNITY_SCALE}) ? UNITY_SCALE : sc_val[SCALE_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Tick commit: packet age, failsafe entry and exit, held sticks and the
  // result word, all taken in one step once the output register is free.
  // --------------------------------------------------------------------------
  logic                 commit;
  logic                 cm_packet;
  logic [SUM_W-1:0]     age_sum, fe_sum;
  logic [TIME_BITS-1:0] age_add, fe_add, age_new, fe_new;
  logic                 fs_new, upd_held, give_held;
  logic [STICK_W-1:0]   t_new, p_new, r_new, y_new;

  assign commit = (state == ST_COMMIT) && (!m_tvalid || m_tready);

  always_comb begin
    cm_packet = packet_mode ? in_arrived : 1'b1;
    age_sum = SUM_W'(packet_age) + SUM_W'(in_dt);
    fe_sum  = SUM_W'(failsafe_elapsed) + SUM_W'(in_dt);
    age_add = (age_sum > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : age_sum[TIME_BITS-1:0];
    fe_add  = (fe_sum > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : fe_sum[TIME_BITS-1:0];
    age_new = (packet_mode && !in_arrived) ? age_add : '0;
    fe_new  = failsafe_elapsed;
    fs_new  = in_failsafe;
    if (!in_failsafe) begin
      if (CMP_W'(age_new) >= CMP_W'(packet_timeout_us)) begin
        fs_new = 1'b1;
        fe_new = '0;
      end
    end else begin
      fe_new = fe_add;
      if (cm_packet) begin
        fs_new  = 1'b0;
        fe_new  = '0;
        age_new = '0;
      end
    end
    upd_held  = !fs_new && cm_packet;
    give_held = !fs_new || (CMP_W'(fe_new) < CMP_W'(hold_time_us));
    t_new = upd_held ? in_throttle  : held_throttle;
    p_new = upd_held ? pitch_scaled : held_pitch;
    r_new = upd_held ? roll_scaled  : held_roll;
    y_new = upd_held ? yaw_scaled   : held_yaw;
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_SETUP;
      ST_SETUP:     state_next = (su_kind == SEG_DIV) ? ST_SEG_MUL : ST_SCALE;
      ST_SEG_MUL:   state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_RUN;
      ST_DIV_RUN:   if (div_stat.done) state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_MUL_PITCH;
      ST_MUL_PITCH: state_next = ST_MUL_ROLL;
      ST_MUL_ROLL:  state_next = ST_MUL_YAW;
      ST_MUL_YAW:   state_next = ST_YAW_CAP;
      ST_YAW_CAP:   state_next = ST_COMMIT;
      ST_COMMIT:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: unit controls.
  // --------------------------------------------------------------------------
  always_comb begin
    s_tready  = 1'b0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SEG_MUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, seg_dmag};
        mul_b  = {2'b00, seg_num};
      end
      ST_DIV_START: div_start = 1'b1;
      ST_MUL_PITCH: begin
        mul_en = 1'b1;
        mul_a  = abs_stick(in_pitch);
        mul_b  = {1'b0, scale};
      end
      ST_MUL_ROLL: begin
        mul_en = 1'b1;
        mul_a  = abs_stick(in_roll);
        mul_b  = {1'b0, scale};
      end
      ST_MUL_YAW: begin
        mul_en = 1'b1;
        mul_a  = abs_stick(in_yaw);
        mul_b  = {1'b0, scale};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers along the sequence.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_dt       <= s_tdata[19:0];
          in_q        <= s_tdata[35] ? s_tdata[34:20] : FULL_QUALITY;
          in_arrived  <= s_tdata[36];
          in_throttle <= s_tdata[52:37];
          in_pitch    <= s_tdata[68:53];
          in_roll     <= s_tdata[84:69];
          in_yaw      <= s_tdata[100:85];
        end
      end
      ST_SETUP: begin
        seg_kind <= su_kind;
        seg_lo   <= su_lo;
        seg_hi   <= su_hi;
        seg_neg  <= su_delta < 0;
        seg_dmag <= su_dmag;
        seg_num  <= su_nn[QUAL_W-1:0];
        seg_den  <= su_dd[QUAL_W-1:0];
      end
      ST_SCALE:    scale        <= sc_next;
      ST_MUL_ROLL: pitch_scaled <= round_stick(in_pitch[STICK_W-1], prod);
      ST_MUL_YAW:  roll_scaled  <= round_stick(in_roll[STICK_W-1], prod);
      ST_YAW_CAP:  yaw_scaled   <= round_stick(in_yaw[STICK_W-1], prod);
      default: ;
    endcase
  end

  // Link state and held sticks.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_failsafe      <= 1'b0;
      packet_age       <= '0;
      failsafe_elapsed <= '0;
      held_throttle    <= '0;
      held_pitch       <= '0;
      held_roll        <= '0;
      held_yaw         <= '0;
    end else if (commit) begin
      in_failsafe      <= fs_new;
      packet_age       <= age_new;
      failsafe_elapsed <= fe_new;
      held_throttle    <= t_new;
      held_pitch       <= p_new;
      held_roll        <= r_new;
      held_yaw         <= y_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata[15:0]  <= give_held ? t_new : '0;
      m_tdata[31:16] <= give_held ? p_new : '0;
      m_tdata[47:32] <= give_held ? r_new : '0;
      m_tdata[63:48] <= give_held ? y_new : '0;
      m_tdata[79:64] <= fs_new ? '0 : scale;
      m_tdata[80]    <= fs_new;
      m_tdata[81]    <= cm_packet;
      m_tdata[87:82] <= '0;
    end
  end

endmodule

// ===== hdl/rclfs_checker.sv =====
// ----------------------------------------------------------------------------
// rclfs_checker: port-level checks for the RC link failsafe scaler
// Watches the stream ports of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module rclfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata
);

  // A stalled result word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed or dropped while stalled");

  // One tick at a time: the block is busy right after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again in the cycle after an accept");

  // Failsafe always reports a zero scale.
  a_failsafe_scale: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[80] |-> m_tdata[79:64] == 16'd0)
    else $error("nonzero scale reported in failsafe");

  // The scale never exceeds unity.
  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[79:64] <= 16'd32768)
    else $error("scale above unity");

endmodule

bind rc_link_failsafe_input_scaler_unit rclfs_checker u_rclfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/rc_link_failsafe_input_scaler_unit_test.sv =====
// ----------------------------------------------------------------------------
// rc_link_failsafe_input_scaler_unit_test: self-checking bench for the scaler
// Drives control ticks through the input stream and collects result words from
// the output stream, with random idle cycles on both sides. A scoreboard class
// keeps its own copy of the registers and the failsafe state and predicts every
// result word. The run covers several register settings.
// ----------------------------------------------------------------------------
module rc_link_failsafe_input_scaler_unit_test;
  import rclfs_pkg::*;

  localparam int TICK_TIME_BITS = TIME_BITS_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int SETTINGS_N = 8;
  localparam int TICKS_PER_SETTING = 170;
  // Cycles to let pass once the last expected word has arrived.
  localparam int SETTLE_CYCLES = 40;

  // One control tick as it enters the block.
  typedef struct {
    logic [DT_W-1:0]           elapsed_us;
    logic [QUAL_W-1:0]         link_quality;
    logic                      quality_valid;
    logic                      packet_arrived;
    logic signed [STICK_W-1:0] throttle_in;
    logic signed [STICK_W-1:0] pitch_in;
    logic signed [STICK_W-1:0] roll_in;
    logic signed [STICK_W-1:0] yaw_in;
  } tick_t;

  // One result word as it leaves the block.
  typedef struct {
    logic signed [STICK_W-1:0] throttle_out;
    logic signed [STICK_W-1:0] pitch_out;
    logic signed [STICK_W-1:0] roll_out;
    logic signed [STICK_W-1:0] yaw_out;
    logic [SCALE_W-1:0]        input_scale;
    logic                      failsafe_active;
    logic                      packet_seen;
  } scaler_out_t;

  // Tracks the link state the same way the block should, and holds the
  // result words that are still due.
  class stick_scoreboard;
    logic [QUAL_W-1:0]  degraded_q, critical_q, cutoff_q;
    logic [SCALE_W-1:0] min_scale, crit_scale;
    logic [US_W-1:0]    timeout_us, hold_us;
    logic               use_arrival;

    bit                 failsafe;
    longint unsigned    age_us, fs_time_us;
    logic [STICK_W-1:0] held_thr, held_pit, held_rol, held_yaw;

    scaler_out_t pending_outputs[$];
    int n_ticks, n_checked, n_errors, n_failsafe, n_zeroed;

    function new();
      degraded_q  = DEGRADED_RESET;
      critical_q  = CRITICAL_RESET;
      cutoff_q    = CUTOFF_RESET;
      min_scale   = MIN_SCALE_RESET;
      crit_scale  = CRIT_SCALE_RESET;
      timeout_us  = TIMEOUT_RESET;
      hold_us     = HOLD_RESET;
      use_arrival = 1'b0;
      failsafe    = 1'b0;
      age_us      = 0;
      fs_time_us  = 0;
      held_thr = '0; held_pit = '0; held_rol = '0; held_yaw = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [US_W-1:0] v);
      case (idx)
        REG_DEGRADED_QUALITY: degraded_q = v[QUAL_W-1:0];
        REG_CRITICAL_QUALITY: critical_q = v[QUAL_W-1:0];
        REG_CUTOFF_QUALITY:   cutoff_q = v[QUAL_W-1:0];
        REG_MINIMUM_SCALE:    min_scale = v[SCALE_W-1:0];
        REG_CRITICAL_SCALE:   crit_scale = v[SCALE_W-1:0];
        REG_PACKET_TIMEOUT:   timeout_us = v;
        REG_HOLD_TIME:        hold_us = v;
        REG_PACKET_MODE:      use_arrival = v[0];
        default: ;
      endcase
    endfunction

    // Times stop at the top of the counter instead of wrapping.
    function longint unsigned time_sum(longint unsigned a, longint unsigned b);
      longint unsigned top, s;
      top = (longint'(1) << TICK_TIME_BITS) - 1;
      s = a + b;
      return (s > top) ? top : s;
    endfunction

    // Linear map of q from [a,b] onto [lo,hi], clamped at both ends. A
    // segment of zero width is a step at b; swapped bounds use the same
    // formula with the signs folded.
    function longint ramp(longint q, longint a, longint b, longint lo, longint hi);
      longint num, den, delta, mag, inc;
      num = q - a;
      den = b - a;
      if (den == 0) return (q >= b) ? hi : lo;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num <= 0) return lo;
      if (num >= den) return hi;
      delta = hi - lo;
      mag = ((delta < 0) ? -delta : delta) * num;
      inc = (mag + den / 2) / den;
      return (delta < 0) ? lo - inc : lo + inc;
    endfunction

    // stick * scale / 1.0, rounded half away from zero.
    function logic [STICK_W-1:0] scale_stick(logic signed [STICK_W-1:0] s, longint scale);
      longint v, mag, r;
      v = s;
      mag = ((v < 0) ? -v : v) * scale;
      r = (mag + UNITY_SCALE / 2) / UNITY_SCALE;
      if (v < 0) r = -r;
      return r[STICK_W-1:0];
    endfunction

    // Called once per accepted tick word; queues the word the block owes.
    function void record_tick(tick_t t);
      longint q, scale;
      bit pkt;
      scaler_out_t e;
      q = t.quality_valid ? longint'(t.link_quality) : longint'(FULL_QUALITY);
      if (q >= degraded_q)
        scale = UNITY_SCALE;
      else if (q <= critical_q)
        scale = ramp(q, cutoff_q, critical_q, min_scale, crit_scale);
      else
        scale = ramp(q, critical_q, degraded_q, crit_scale, UNITY_SCALE);
      if (scale > UNITY_SCALE) scale = UNITY_SCALE;
      if (scale < 0) scale = 0;

      if (use_arrival) begin
        pkt = t.packet_arrived;
        age_us = time_sum(age_us, t.elapsed_us);
        if (pkt) age_us = 0;
      end else begin
        pkt = 1'b1;
        age_us = 0;
      end

      if (!failsafe) begin
        if (age_us >= timeout_us) begin
          failsafe = 1'b1;
          fs_time_us = 0;
        end
      end else begin
        fs_time_us = time_sum(fs_time_us, t.elapsed_us);
        if (pkt) begin
          failsafe = 1'b0;
          fs_time_us = 0;
          age_us = 0;
        end
      end

      if (failsafe) begin
        scale = 0;
        n_failsafe++;
        if (fs_time_us < hold_us) begin
          e.throttle_out = held_thr; e.pitch_out = held_pit;
          e.roll_out = held_rol; e.yaw_out = held_yaw;
        end else begin
          n_zeroed++;
          e.throttle_out = '0; e.pitch_out = '0; e.roll_out = '0; e.yaw_out = '0;
        end
      end else begin
        // Without a packet the last delivered sticks simply repeat.
        if (pkt) begin
          held_thr = t.throttle_in;
          held_pit = scale_stick(t.pitch_in, scale);
          held_rol = scale_stick(t.roll_in, scale);
          held_yaw = scale_stick(t.yaw_in, scale);
        end
        e.throttle_out = held_thr; e.pitch_out = held_pit;
        e.roll_out = held_rol; e.yaw_out = held_yaw;
      end
      e.input_scale = scale[SCALE_W-1:0];
      e.failsafe_active = failsafe;
      e.packet_seen = pkt;
      pending_outputs.push_back(e);
      n_ticks++;
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        n_errors++;
      end
    endfunction

    // Called for every result word taken from the block.
    function void check_output(logic [87:0] w);
      scaler_out_t got, want;
      got.throttle_out    = w[15:0];
      got.pitch_out       = w[31:16];
      got.roll_out        = w[47:32];
      got.yaw_out         = w[63:48];
      got.input_scale     = w[79:64];
      got.failsafe_active = w[80];
      got.packet_seen     = w[81];
      n_checked++;
      if (pending_outputs.size() == 0) begin
        $error("result word arrived with no tick waiting for it");
        n_errors++;
        return;
      end
      want = pending_outputs.pop_front();
      compare_field("throttle_out", want.throttle_out, got.throttle_out);
      compare_field("pitch_out", want.pitch_out, got.pitch_out);
      compare_field("roll_out", want.roll_out, got.roll_out);
      compare_field("yaw_out", want.yaw_out, got.yaw_out);
      compare_field("input_scale", want.input_scale, got.input_scale);
      compare_field("failsafe_active", want.failsafe_active, got.failsafe_active);
      compare_field("packet_seen", want.packet_seen, got.packet_seen);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [103:0]         s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [87:0]          m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [US_W-1:0]      cfg_data;

  stick_scoreboard sb = new();
  int unsigned cycle_count = 0;
  // Ticks left in the current simulated radio outage (no packets).
  int outage_left;

  // Register settings, one row per phase, columns in register index order:
  // degraded, critical, cutoff, minimum scale, critical scale, timeout,
  // hold time, packet mode.
  int unsigned plan_regs [SETTINGS_N][8] = '{
    // Reset values: every tick counts as a packet.
    '{17920, 10240, 2560, 8192, 19661, 500000, 1000000, 0},
    // Short timeout and hold, so failsafe is entered and the hold runs out.
    '{17920, 10240, 2560, 8192, 19661, 4000, 12000, 1},
    // Zero timeout and zero hold: failsafe is entered on every tick outside it, sticks cut at once.
    '{20000, 12000, 4000, 0, 32768, 0, 0, 1},
    // Top thresholds and the largest times.
    '{25600, 25600, 0, 0, 32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1},
    // Zero-width segments, a critical scale past 1.0, and a half scale that
    // puts odd sticks on rounding ties.
    '{12800, 12800, 12800, 16384, 65535, 300000, 2000000, 1},
    // Lower segment with its bounds swapped.
    '{16000, 8000, 25600, 32768, 0, 6000, 6000, 1},
    // Falling lower segment: the scale drops as quality rises.
    '{24000, 6000, 1000, 30000, 1000, 2000, 50000, 1},
    // All thresholds at zero: the scale is always one; hold never runs out.
    '{0, 0, 0, 0, 0, 10000, 32'hFFFF_FFFF, 1}
  };
  // Largest elapsed time drawn for each phase, matched to its timeout.
  int unsigned plan_dt [SETTINGS_N] = '{1000000, 1500, 3000, 1000000, 1000000, 2500, 900, 4000};

  rc_link_failsafe_input_scaler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Every result word taken at a rising edge goes to the scoreboard. The
  // values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_output(m_tdata);
  end

  // Idle length between words: mostly none or short, now and then long.
  function automatic int pick_gap(bit eager);
    int r;
    if (eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // Input word layout from bit 0, with zero fill at the top.
  function automatic logic [103:0] pack_tick(tick_t t);
    return {3'b000, t.yaw_in, t.roll_in, t.pitch_in, t.throttle_in,
            t.packet_arrived, t.quality_valid, t.link_quality, t.elapsed_us};
  endfunction

  function automatic tick_t mk_tick(int unsigned dt, int unsigned lq, bit qv, bit pa,
                                    int thr, int pit, int rol, int yw);
    tick_t t;
    t.elapsed_us = dt[DT_W-1:0];
    t.link_quality = lq[QUAL_W-1:0];
    t.quality_valid = qv;
    t.packet_arrived = pa;
    t.throttle_in = thr[STICK_W-1:0];
    t.pitch_in = pit[STICK_W-1:0];
    t.roll_in = rol[STICK_W-1:0];
    t.yaw_in = yw[STICK_W-1:0];
    return t;
  endfunction

  function automatic logic [STICK_W-1:0] rand_stick();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return STICK_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random tick. Packets come in runs broken by outages of random length,
  // so the failsafe entry, hold and recovery paths are all reached.
  function automatic tick_t rand_tick(int unsigned dt_max);
    tick_t t;
    int r, q, edge_q;
    r = $urandom_range(0, 99);
    if (r < 10) t.elapsed_us = '0;
    else if (r < 15) t.elapsed_us = DT_W'(dt_max);
    else t.elapsed_us = DT_W'($urandom_range(0, dt_max));

    r = $urandom_range(0, 99);
    if (r < 30) begin
      // Near one of the thresholds, where the segment edges sit.
      case ($urandom_range(0, 2))
        0: edge_q = int'(sb.degraded_q);
        1: edge_q = int'(sb.critical_q);
        default: edge_q = int'(sb.cutoff_q);
      endcase
      q = edge_q + $urandom_range(0, 6) - 3;
      if (q < 0) q = 0;
      if (q > 32767) q = 32767;
    end else if (r < 85) q = $urandom_range(0, 25600);
    else if (r < 93) q = $urandom_range(25601, 32767);
    else q = ($urandom_range(0, 1) != 0) ? 25600 : 0;
    t.link_quality = QUAL_W'(q);
    t.quality_valid = ($urandom_range(0, 99) < 88);

    if (outage_left > 0) begin
      outage_left--;
      t.packet_arrived = 1'b0;
    end else if ($urandom_range(0, 99) < 10) begin
      outage_left = $urandom_range(2, 30);
      t.packet_arrived = 1'b0;
    end else begin
      t.packet_arrived = ($urandom_range(0, 99) < 80);
    end

    t.throttle_in = rand_stick();
    t.pitch_in = rand_stick();
    t.roll_in = rand_stick();
    t.yaw_in = rand_stick();
    return t;
  endfunction

  // Offer one tick word and hold it until the block takes it. Entered and
  // left at a falling edge; valid stays high into the next word when there
  // is no gap.
  task automatic send_tick(tick_t t, bit eager);
    int gap;
    s_tdata = pack_tick(t);
    s_tvalid = 1'b1;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.record_tick(t);
    @(negedge clk);
    gap = pick_gap(eager);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [US_W-1:0] v);
    cfg_index = idx;
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering words, wait until every expected word has come back, then
  // let the block settle.
  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: ready in stretches of random length with random stalls in
  // between. Once, after a few hundred words, it holds off for a long
  // stretch so the block backs up and stops taking input.
  initial begin : receiver
    int stretch, gap;
    bit held_done;
    m_tready = 1'b0;
    held_done = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!held_done && sb.n_checked >= 300) begin
        m_tready = 1'b0;
        repeat (600) @(negedge clk);
        held_done = 1'b1;
      end
      m_tready = 1'b1;
      stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      repeat (stretch) @(negedge clk);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int n_settings;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEGRADED_QUALITY;
    cfg_data = '0;
    outage_left = 0;
    n_settings = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed ticks with the reset settings: quality at zero, at each
    // threshold, just under the degraded one, at and above 100 percent, and
    // marked invalid, with the stick extremes and small odd values.
    send_tick(mk_tick(100, 0, 1, 0, 32767, 32767, -32768, 0), 1'b0);
    send_tick(mk_tick(100, 2560, 1, 1, -32768, -32768, 32767, 1), 1'b0);
    send_tick(mk_tick(100, 10240, 1, 0, 1, -1, 12345, -12345), 1'b0);
    send_tick(mk_tick(100, 17920, 1, 0, -1, 32767, -32768, 3), 1'b0);
    send_tick(mk_tick(100, 17919, 1, 1, 0, -32768, 1, -1), 1'b0);
    send_tick(mk_tick(100, 25600, 1, 0, 100, 200, 300, 400), 1'b0);
    send_tick(mk_tick(100, 32767, 1, 0, -100, -200, -300, -400), 1'b0);
    send_tick(mk_tick(100, 0, 0, 0, 5, 7, -9, 11), 1'b0);
    send_tick(mk_tick(0, 6000, 1, 0, 32767, 1001, -1001, 32767), 1'b0);
    send_tick(mk_tick(1000000, 14000, 1, 1, -32768, -5, 5, -32768), 1'b0);

    // Packet-driven mode with a short timeout and hold: a missed packet
    // repeats the held sticks, the timeout enters failsafe, the hold runs
    // out to zeros, and a packet brings the link back.
    drain();
    write_reg(REG_PACKET_TIMEOUT, 1000);
    write_reg(REG_HOLD_TIME, 1500);
    write_reg(REG_PACKET_MODE, 1);
    n_settings++;
    send_tick(mk_tick(600, 20000, 1, 1, 1000, 2000, -3000, 4000), 1'b0);
    send_tick(mk_tick(400, 20000, 1, 0, 9, 9, 9, 9), 1'b0);
    send_tick(mk_tick(600, 20000, 1, 0, 9, 9, 9, 9), 1'b0);
    send_tick(mk_tick(800, 20000, 1, 0, 9, 9, 9, 9), 1'b0);
    send_tick(mk_tick(800, 20000, 1, 0, 9, 9, 9, 9), 1'b0);
    send_tick(mk_tick(50, 8000, 1, 1, -7000, 7000, -32768, 32767), 1'b0);

    // Zero timeout: failsafe is entered even with a packet and left on the
    // next packet.
    drain();
    write_reg(REG_PACKET_TIMEOUT, 0);
    n_settings++;
    send_tick(mk_tick(10, 20000, 1, 1, 111, 222, 333, 444), 1'b0);
    send_tick(mk_tick(10, 20000, 1, 1, 555, 666, 777, 888), 1'b0);
    send_tick(mk_tick(10, 20000, 1, 0, 1, 2, 3, 4), 1'b0);
    send_tick(mk_tick(10, 20000, 1, 1, -1, -2, -3, -4), 1'b0);

    // Random phases, one per register setting. The first quarter of every
    // hundred ticks is sent back to back.
    for (int p = 0; p < SETTINGS_N; p++) begin
      drain();
      for (int k = 0; k < 8; k++) write_reg(cfg_reg_t'(k), plan_regs[p][k]);
      n_settings++;
      outage_left = 0;
      for (int i = 0; i < TICKS_PER_SETTING; i++)
        send_tick(rand_tick(plan_dt[p]), (i % 100) < 25);
    end

    s_tvalid = 1'b0;
    drain();

    $display("Sent %0d ticks over %0d register settings and checked %0d result words.",
             sb.n_ticks, n_settings, sb.n_checked);
    $display("%0d results were in failsafe, %0d of them with sticks cut to zero.",
             sb.n_failsafe, sb.n_zeroed);
    if (sb.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
